// ===== rtl/core/eht_pkg.sv =====
`default_nettype none
package eht_pkg;

  // Table geometry
  localparam int SLOTS   = 8;
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam int ADDR_W = 48;
  localparam int TIME_W = 63;
  localparam int TMO_W  = 32;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd30000000;

  // func codes
  localparam logic [1:0] FUNC_FRAME   = 2'd0;
  localparam logic [1:0] FUNC_CLEANUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // event codes
  localparam logic [2:0] EV_IGNORED  = 3'd0;
  localparam logic [2:0] EV_TRACKED  = 3'd1;
  localparam logic [2:0] EV_ARMED    = 3'd2;
  localparam logic [2:0] EV_COMPLETE = 3'd3;
  localparam logic [2:0] EV_CLEANUP  = 3'd4;
  localparam logic [2:0] EV_CLEARED  = 3'd5;

  // key information bits
  localparam logic [15:0] KF_PAIRWISE = 16'h0008;
  localparam logic [15:0] KF_INSTALL  = 16'h0040;
  localparam logic [15:0] KF_ACK      = 16'h0080;
  localparam logic [15:0] KF_MIC      = 16'h0100;

  localparam logic [7:0] DS_TO    = 8'h01;
  localparam logic [7:0] DS_FROM  = 8'h02;
  localparam logic [7:0] KIND_KEY = 8'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        frame_flags;
    logic [ADDR_W-1:0] addr_one;
    logic [ADDR_W-1:0] addr_two;
    logic [ADDR_W-1:0] ap_id;
    logic [7:0]        eapol_kind;
    logic [15:0]       key_flags;
    logic              long_enough;
    logic              authorized;
    logic [TIME_W-1:0] now_us;
  } eht_in_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [2:0]        slot;
    logic [ADDR_W-1:0] client_id;
    logic [3:0]        stale_count;
    logic [3:0]        active_count;
  } eht_out_t;

  // Lookup key broadcast to every cell
  typedef struct packed {
    logic [ADDR_W-1:0] ap;
    logic [ADDR_W-1:0] client;
    logic [TIME_W-1:0] now;
    logic [TMO_W-1:0]  timeout;
  } eht_qry_t;

  // Partial scan result handed from cell to cell
  typedef struct packed {
    logic               match_found;
    logic [SLOT_IW-1:0] match_idx;
    logic               match_armed;
    logic               have_free;
    logic [SLOT_IW-1:0] free_idx;
    logic               best_set;
    logic [SLOT_IW-1:0] best_idx;
    logic [TIME_W-1:0]  best_time;
    logic               best_armed;
    logic [3:0]         stale_cnt;
    logic [CNT_W-1:0]   armed_all;
    logic [CNT_W-1:0]   armed_keep;
  } eht_acc_t;

  localparam eht_acc_t ACC_INIT = '0;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_CLEANUP,
    CMD_CLEAR
  } eht_cmd_e;

  typedef struct packed {
    eht_cmd_e           kind;
    logic [SLOT_IW-1:0] idx;
    logic               alloc;
    logic               armed;
    logic               stamp;
  } eht_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } eht_state_e;

  // Slot index masked to the three bits of the result field
  function automatic logic [2:0] slot3(input logic [SLOT_IW-1:0] idx);
    logic [SLOT_IW+2:0] w;
    w = {3'b000, idx};
    return w[2:0];
  endfunction

  // Saturate a slot count at 15
  function automatic logic [3:0] sat15(input logic [CNT_W-1:0] n);
    logic [CNT_W+3:0] w;
    w = {4'b0000, n};
    if (w > (CNT_W+4)'(15)) begin
      return 4'd15;
    end
    return w[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/eht_cell.sv =====
`default_nettype none
module eht_cell
  import eht_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SLOT_IW-1:0] cell_idx_i,
  input  eht_qry_t           qry_i,
  input  eht_cmd_t           cmd_i,
  input  eht_acc_t           acc_i,
  output eht_acc_t           acc_o
);

  logic              valid_q, valid_d;
  logic              armed_q, armed_d;
  logic [ADDR_W-1:0] ap_q;
  logic [ADDR_W-1:0] client_q;
  logic [TIME_W-1:0] time_q;
  eht_acc_t          acc_q, acc_d;

  logic              hit;
  logic              stale;
  logic              sel;
  logic [TIME_W-1:0] age;

  // Pair match and staleness of this slot
  assign hit   = valid_q && (ap_q == qry_i.ap) && (client_q == qry_i.client);
  assign age   = qry_i.now - time_q;
  assign stale = valid_q && (qry_i.now > time_q) &&
                 (age > {{(TIME_W-TMO_W){1'b0}}, qry_i.timeout});
  assign sel   = (cmd_i.idx == cell_idx_i);

  // Fold this slot into the travelling scan result
  always_comb begin
    acc_d = acc_i;
    if (hit && !acc_i.match_found) begin
      acc_d.match_found = 1'b1;
      acc_d.match_idx   = cell_idx_i;
      acc_d.match_armed = armed_q;
    end
    if (!valid_q) begin
      acc_d.have_free = 1'b1;
      acc_d.free_idx  = cell_idx_i;
    end else if (!acc_i.have_free && (!acc_i.best_set || time_q < acc_i.best_time)) begin
      acc_d.best_set   = 1'b1;
      acc_d.best_idx   = cell_idx_i;
      acc_d.best_time  = time_q;
      acc_d.best_armed = armed_q;
    end
    if (stale && acc_i.stale_cnt != 4'd15) begin
      acc_d.stale_cnt = acc_i.stale_cnt + 4'd1;
    end
    if (valid_q && armed_q) begin
      acc_d.armed_all = acc_i.armed_all + CNT_W'(1);
      if (!stale) begin
        acc_d.armed_keep = acc_i.armed_keep + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

  // Slot flags
  always_comb begin
    valid_d = valid_q;
    armed_d = armed_q;
    unique case (cmd_i.kind)
      CMD_CLEAR: begin
        valid_d = 1'b0;
        armed_d = 1'b0;
      end
      CMD_CLEANUP: begin
        if (stale) begin
          valid_d = 1'b0;
          armed_d = 1'b0;
        end
      end
      CMD_WRITE: begin
        if (sel) begin
          if (cmd_i.alloc) begin
            valid_d = 1'b1;
          end
          armed_d = cmd_i.armed;
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      armed_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      armed_q <= armed_d;
    end
  end

  // Slot payload, only read while the slot is valid
  always_ff @(posedge clk_i) begin
    if (cmd_i.kind == CMD_WRITE && sel) begin
      if (cmd_i.alloc) begin
        ap_q     <= qry_i.ap;
        client_q <= qry_i.client;
      end
      if (cmd_i.stamp) begin
        time_q <= qry_i.now;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/eht_ctrl.sv =====
`default_nettype none
module eht_ctrl
  import eht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  eht_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output eht_out_t    out_data_o,
  input  eht_acc_t    acc_i,
  output eht_qry_t    qry_o,
  output eht_cmd_t    cmd_o
);

  localparam logic [SLOT_IW-1:0] CNT_LAST = SLOT_IW'(SLOTS - 1);

  eht_state_e         state_q, state_d;
  logic [SLOT_IW-1:0] cnt_q, cnt_d;
  logic [TMO_W-1:0]   timeout_q;
  eht_in_t            item_q;
  logic               out_valid_q;
  eht_out_t           out_data_q;

  logic               in_fire;
  logic               out_free;
  logic               to_ds, from_ds;
  logic               mic, ack, inst;
  logic               track;
  logic [ADDR_W-1:0]  client;
  logic [SLOT_IW-1:0] chosen;
  logic               cur_armed;
  logic               eff_armed;
  logic               new_armed;
  logic               stamp;
  logic [CNT_W-1:0]   frame_cnt;
  eht_cmd_e           cmd_kind;
  eht_out_t           res;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Captured transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
  end

  // Frame decode
  assign to_ds   = (item_q.frame_flags & DS_TO) != 8'd0;
  assign from_ds = (item_q.frame_flags & DS_FROM) != 8'd0;
  assign mic     = (item_q.key_flags & KF_MIC) != 16'd0;
  assign ack     = (item_q.key_flags & KF_ACK) != 16'd0;
  assign inst    = (item_q.key_flags & KF_INSTALL) != 16'd0;
  assign track   = item_q.authorized && item_q.long_enough && (to_ds != from_ds) &&
                   (item_q.eapol_kind == KIND_KEY) &&
                   ((item_q.key_flags & KF_PAIRWISE) != 16'd0);
  assign client  = to_ds ? item_q.addr_two : item_q.addr_one;

  assign qry_o.ap      = item_q.ap_id;
  assign qry_o.client  = client;
  assign qry_o.now     = item_q.now_us;
  assign qry_o.timeout = timeout_q;

  // Slot choice from the finished scan
  always_comb begin
    if (acc_i.match_found) begin
      chosen    = acc_i.match_idx;
      cur_armed = acc_i.match_armed;
      eff_armed = acc_i.match_armed;
    end else if (acc_i.have_free) begin
      chosen    = acc_i.free_idx;
      cur_armed = 1'b0;
      eff_armed = 1'b0;
    end else begin
      chosen    = acc_i.best_idx;
      cur_armed = acc_i.best_armed;
      eff_armed = 1'b0;
    end
  end

  // Result and table command
  always_comb begin
    res       = '0;
    cmd_kind  = CMD_NONE;
    new_armed = eff_armed;
    stamp     = !acc_i.match_found;
    res.active_count = sat15(acc_i.armed_all);
    priority if (!mic && ack) begin
      new_armed = 1'b1;
      stamp     = 1'b1;
    end else if (mic && !inst && !ack && eff_armed) begin
      new_armed = 1'b0;
      stamp     = 1'b1;
    end else begin
      // other key frames keep the slot as found
    end
    frame_cnt = acc_i.armed_all - CNT_W'(cur_armed) + CNT_W'(new_armed);
    unique case (item_q.func)
      FUNC_FRAME: begin
        if (track) begin
          cmd_kind = CMD_WRITE;
          res.slot      = slot3(chosen);
          res.client_id = client;
          res.active_count = sat15(frame_cnt);
          priority if (!mic && ack) begin
            res.event_res = EV_ARMED;
          end else if (mic && !inst && !ack && eff_armed) begin
            res.event_res = EV_COMPLETE;
          end else begin
            res.event_res = EV_TRACKED;
          end
        end
      end
      FUNC_CLEANUP: begin
        cmd_kind         = CMD_CLEANUP;
        res.event_res    = EV_CLEANUP;
        res.stale_count  = acc_i.stale_cnt;
        res.active_count = sat15(acc_i.armed_keep);
      end
      FUNC_CLEAR: begin
        cmd_kind         = CMD_CLEAR;
        res.event_res    = EV_CLEARED;
        res.active_count = 4'd0;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + SLOT_IW'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.kind  = CMD_NONE;
    cmd_o.idx   = chosen;
    cmd_o.alloc = !acc_i.match_found;
    cmd_o.armed = new_armed;
    cmd_o.stamp = stamp;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SCAN: begin
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd_o.kind = cmd_kind;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_UPDATE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE && out_free) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/eapol_handshake_pair_tracker.sv =====
// Handshake pair tracker: a row of SLOTS table cells, each holding one
// access-point/client pair, with a controller in front. A transaction is taken
// when the block is idle; a lookup record then travels down the cell row one
// cell per cycle. A transaction passes through an accept step, a scan of the
// cell row and an update step that waits for the output register to be free,
// before its result lands in the output register. The next transaction may be
// accepted while that result still waits. The table flags are cleared directly
// by reset, with no clearing pass; the stale timeout may be rewritten at any
// idle time through cfg_we_i / cfg_wdata_i.
`default_nettype none
module eapol_handshake_pair_tracker
  import eht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  eht_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output eht_out_t    out_data_o
);

  eht_acc_t acc_chain [SLOTS+1];
  eht_qry_t qry;
  eht_cmd_t cmd;

  assign acc_chain[0] = ACC_INIT;

  eht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .acc_i       (acc_chain[SLOTS]),
    .qry_o       (qry),
    .cmd_o       (cmd)
  );

  // Cell row
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    eht_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (SLOT_IW'(i)),
      .qry_i      (qry),
      .cmd_i      (cmd),
      .acc_i      (acc_chain[i]),
      .acc_o      (acc_chain[i+1])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/core/eht_checker.sv =====
`default_nettype none
module eht_checker
  import eht_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input eht_out_t    out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  // Stale count only reported by cleanup
  a_stale_only_cleanup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != EV_CLEANUP) |-> out_data_o.stale_count == 4'd0)
    else $error("stale count outside cleanup");

  // Clear leaves nothing armed
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == EV_CLEARED) |-> out_data_o.active_count == 4'd0)
    else $error("armed slots after clear");

  // Untracked results carry no slot or client
  a_untracked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == EV_IGNORED ||
                    out_data_o.event_res == EV_CLEANUP ||
                    out_data_o.event_res == EV_CLEARED)
    |-> out_data_o.slot == 3'd0 && out_data_o.client_id == '0)
    else $error("slot or client set on untracked result");

endmodule

bind eapol_handshake_pair_tracker eht_checker u_eht_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import eht_pkg::*;

  // func value with no meaning; the block must report it as ignored
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int POOL_AP = 2;
  localparam int POOL_CL = 6;
  localparam int PAIRS   = POOL_AP * POOL_CL;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  eht_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  eht_out_t    out_data_o;

  eapol_handshake_pair_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the pair table and the timeout register
  logic              pair_valid  [SLOTS];
  logic [ADDR_W-1:0] pair_ap     [SLOTS];
  logic [ADDR_W-1:0] pair_client [SLOTS];
  logic              pair_armed  [SLOTS];
  logic [TIME_W-1:0] pair_stamp  [SLOTS];
  logic [TMO_W-1:0]  stale_tmo;

  eht_in_t     pending_items[$];
  eht_out_t    expected_events[$];
  int unsigned offered_cnt;
  int unsigned taken_cnt;
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_left;

  // Stimulus helpers
  logic [ADDR_W-1:0] ap_pool     [POOL_AP];
  logic [ADDR_W-1:0] client_pool [POOL_CL];
  int                armed_hist[$];
  logic [TIME_W-1:0] cur_us;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      pair_valid[i]  = 1'b0;
      pair_ap[i]     = '0;
      pair_client[i] = '0;
      pair_armed[i]  = 1'b0;
      pair_stamp[i]  = '0;
    end
  endfunction

  // Expected result of one transaction; updates the shadow table
  function automatic eht_out_t predict_event(eht_in_t it);
    eht_out_t          r;
    logic              is_to;
    logic              is_from;
    logic              have_free;
    logic              mic;
    logic              ack;
    logic              inst;
    logic [ADDR_W-1:0] cl;
    logic [TIME_W-1:0] best;
    int                s;
    int                n;
    r = '0;
    case (it.func)
      FUNC_FRAME: begin
        is_to   = (it.frame_flags & DS_TO) != 0;
        is_from = (it.frame_flags & DS_FROM) != 0;
        if (it.authorized && it.long_enough && is_to != is_from &&
            it.eapol_kind == KIND_KEY && (it.key_flags & KF_PAIRWISE) != 0) begin
          cl = is_to ? it.addr_two : it.addr_one;
          s  = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (s < 0 && pair_valid[i] && pair_ap[i] == it.ap_id && pair_client[i] == cl)
              s = i;
          end
          // no match: last free slot, else first of the oldest
          if (s < 0) begin
            have_free = 1'b0;
            best      = '0;
            s         = 0;
            for (int i = 0; i < SLOTS; i++) begin
              if (!pair_valid[i]) begin
                s         = i;
                have_free = 1'b1;
              end else if (!have_free && (i == 0 || pair_stamp[i] < best)) begin
                s    = i;
                best = pair_stamp[i];
              end
            end
            pair_valid[s]  = 1'b1;
            pair_ap[s]     = it.ap_id;
            pair_client[s] = cl;
            pair_armed[s]  = 1'b0;
            pair_stamp[s]  = it.now_us;
          end
          mic  = (it.key_flags & KF_MIC) != 0;
          ack  = (it.key_flags & KF_ACK) != 0;
          inst = (it.key_flags & KF_INSTALL) != 0;
          r.event_res = EV_TRACKED;
          r.slot      = 3'(s);
          r.client_id = cl;
          if (!mic && ack) begin
            pair_armed[s] = 1'b1;
            pair_stamp[s] = it.now_us;
            r.event_res   = EV_ARMED;
          end else if (mic && !inst && !ack && pair_armed[s]) begin
            pair_armed[s] = 1'b0;
            pair_stamp[s] = it.now_us;
            r.event_res   = EV_COMPLETE;
          end
        end
      end
      FUNC_CLEANUP: begin
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          // a stamp in the future never counts as stale
          if (pair_valid[i] && it.now_us > pair_stamp[i] &&
              it.now_us - pair_stamp[i] > stale_tmo) begin
            pair_valid[i] = 1'b0;
            pair_armed[i] = 1'b0;
            n++;
          end
        end
        r.stale_count = (n > 15) ? 4'd15 : 4'(n);
        r.event_res   = EV_CLEANUP;
      end
      FUNC_CLEAR: begin
        wipe_table();
        r.event_res = EV_CLEARED;
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pair_valid[i] && pair_armed[i])
        n++;
    end
    r.active_count = (n > 15) ? 4'd15 : 4'(n);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // Mostly small forward steps, some big jumps, some steps back
  function automatic logic [TIME_W-1:0] next_us();
    case ($urandom_range(0, 9))
      0:       cur_us = cur_us - TIME_W'($urandom_range(0, 4000));
      1:       cur_us = cur_us + TIME_W'($urandom) * TIME_W'($urandom_range(1, 2));
      default: cur_us = cur_us + TIME_W'($urandom_range(0, 2000));
    endcase
    return cur_us;
  endfunction

  function automatic logic [15:0] msg1_flags();
    return (16'($urandom) & ~KF_MIC) | KF_ACK | KF_PAIRWISE;
  endfunction

  function automatic logic [15:0] msg2_flags();
    return (16'($urandom) & ~(KF_INSTALL | KF_ACK)) | KF_MIC | KF_PAIRWISE;
  endfunction

  // Well-formed EAPOL-Key frame for one pair
  function automatic eht_in_t key_msg(logic [ADDR_W-1:0] ap, logic [ADDR_W-1:0] cl,
                                      logic to_ds, logic [15:0] kf, logic [TIME_W-1:0] now);
    eht_in_t it;
    it.func        = FUNC_FRAME;
    it.frame_flags = (8'($urandom) & ~(DS_TO | DS_FROM)) | (to_ds ? DS_TO : DS_FROM);
    it.addr_one    = to_ds ? rand48() : cl;
    it.addr_two    = to_ds ? cl : rand48();
    it.ap_id       = ap;
    it.eapol_kind  = KIND_KEY;
    it.key_flags   = kf;
    it.long_enough = 1'b1;
    it.authorized  = 1'b1;
    it.now_us      = now;
    return it;
  endfunction

  // Any func at the given time, with every other field random
  function automatic eht_in_t ctl_item(logic [1:0] fn, logic [TIME_W-1:0] now);
    eht_in_t it;
    it.func        = fn;
    it.frame_flags = 8'($urandom);
    it.addr_one    = rand48();
    it.addr_two    = rand48();
    it.ap_id       = rand48();
    it.eapol_kind  = 8'($urandom);
    it.key_flags   = 16'($urandom);
    it.long_enough = 1'($urandom);
    it.authorized  = 1'($urandom);
    it.now_us      = now;
    return it;
  endfunction

  function automatic eht_in_t random_item();
    eht_in_t           it;
    int                pick;
    int                p;
    logic              to_ds;
    logic [ADDR_W-1:0] ap;
    logic [ADDR_W-1:0] cl;
    pick  = $urandom_range(0, 99);
    to_ds = 1'($urandom);
    if (pick < 86) begin
      // message 2 mostly aims at a pair that was recently armed
      if (pick >= 45 && pick < 75 && armed_hist.size() > 0 && $urandom_range(0, 9) < 7)
        p = armed_hist[$urandom_range(0, armed_hist.size() - 1)];
      else
        p = $urandom_range(0, PAIRS - 1);
      if ($urandom_range(0, 9) == 0) begin
        ap = rand48();
        cl = rand48();
      end else begin
        ap = ap_pool[p / POOL_CL];
        cl = client_pool[p % POOL_CL];
      end
      if (pick < 45) begin
        it = key_msg(ap, cl, to_ds, msg1_flags(), next_us());
        armed_hist.push_back(p);
        if (armed_hist.size() > 4)
          void'(armed_hist.pop_front());
      end else if (pick < 75) begin
        it = key_msg(ap, cl, to_ds, msg2_flags(), next_us());
      end else if (pick < 80) begin
        it = key_msg(ap, cl, to_ds, 16'($urandom) | KF_PAIRWISE, next_us());
      end else begin
        // broken frame: one qualifying condition fails
        it = key_msg(ap, cl, to_ds, $urandom_range(0, 1) ? msg1_flags() : msg2_flags(),
                     next_us());
        case ($urandom_range(0, 4))
          0: it.authorized = 1'b0;
          1: it.long_enough = 1'b0;
          2: it.frame_flags = $urandom_range(0, 1) ? (it.frame_flags | DS_TO | DS_FROM)
                                                   : (it.frame_flags & ~(DS_TO | DS_FROM));
          3: it.eapol_kind = KIND_KEY ^ 8'($urandom_range(1, 255));
          default: it.key_flags = it.key_flags & ~KF_PAIRWISE;
        endcase
      end
    end else if (pick < 92) begin
      it = ctl_item(FUNC_CLEANUP, next_us());
    end else if (pick < 93) begin
      it = ctl_item(FUNC_CLEAR, next_us());
    end else begin
      it = ctl_item(2'($urandom_range(0, 3)), next_us());
    end
    return it;
  endfunction

  // Wait until no transaction is queued, in flight or owed
  task automatic drain();
    while (pending_items.size() != 0 || taken_cnt != offered_cnt ||
           expected_events.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_timeout(logic [TMO_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    stale_tmo    = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: bursts of transactions with random gaps
  always @(negedge clk_i) begin
    logic    nxt_valid;
    eht_in_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (rst_ni) begin
      if (in_valid_i && taken_cnt == offered_cnt)
        nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          nxt_data  = pending_items.pop_front();
          nxt_valid = 1'b1;
          offered_cnt++;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // Receiver: alternating ready runs and stalls
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = out_ready_i;
    if (rx_left > 0) begin
      rx_left--;
    end else begin
      nxt_ready = !out_ready_i;
      if (nxt_ready)
        rx_left = $urandom_range(0, 40);
      else
        rx_left = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(3, 20);
    end
    out_ready_i <= nxt_ready;
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    eht_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_events.push_back(predict_event(in_data_i));
        taken_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("result transaction with nothing expected: %p", out_data_o);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", want.event_res, out_data_o.event_res);
          check_field("slot", want.slot, out_data_o.slot);
          check_field("client_id", want.client_id, out_data_o.client_id);
          check_field("stale_count", want.stale_count, out_data_o.stale_count);
          check_field("active_count", want.active_count, out_data_o.active_count);
        end
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] ap_a;
    logic [ADDR_W-1:0] dir_cl [9];
    logic [TMO_W-1:0]  tmo_set [5];
    eht_in_t           it;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    offered_cnt = 0;
    taken_cnt   = 0;
    mismatches  = 0;
    burst_left  = 0;
    gap_left    = 0;
    rx_left     = 0;
    stale_tmo   = TIMEOUT_RST;
    cur_us      = TIME_W'(1000);
    wipe_table();
    foreach (ap_pool[i]) ap_pool[i] = rand48();
    foreach (client_pool[i]) client_pool[i] = rand48();
    foreach (dir_cl[i]) dir_cl[i] = rand48();
    ap_a = rand48();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, reset timeout
    pending_items.push_back(ctl_item(FUNC_CLEAR, next_us()));
    pending_items.push_back(ctl_item(FUNC_CLEANUP, next_us()));
    pending_items.push_back(ctl_item(FUNC_UNUSED, next_us()));
    // arm, complete, then message 2 again on a disarmed slot
    pending_items.push_back(key_msg(ap_a, dir_cl[0], 1'b1, msg1_flags(), next_us()));
    pending_items.push_back(key_msg(ap_a, dir_cl[0], 1'b1, msg2_flags(), next_us()));
    pending_items.push_back(key_msg(ap_a, dir_cl[0], 1'b1, msg2_flags(), next_us()));
    pending_items.push_back(key_msg(ap_a, dir_cl[1], 1'b0, msg1_flags(), next_us()));
    // each reason for a frame to be ignored
    it = key_msg(ap_a, dir_cl[1], 1'b0, msg2_flags(), next_us());
    it.frame_flags = it.frame_flags | DS_TO | DS_FROM;
    pending_items.push_back(it);
    it.frame_flags = it.frame_flags & ~(DS_TO | DS_FROM);
    pending_items.push_back(it);
    it = key_msg(ap_a, dir_cl[1], 1'b0, msg2_flags(), next_us());
    it.authorized = 1'b0;
    pending_items.push_back(it);
    it.authorized  = 1'b1;
    it.long_enough = 1'b0;
    pending_items.push_back(it);
    it.long_enough = 1'b1;
    it.eapol_kind  = KIND_KEY ^ 8'h01;
    pending_items.push_back(it);
    it.eapol_kind = KIND_KEY;
    it.key_flags  = it.key_flags & ~KF_PAIRWISE;
    pending_items.push_back(it);
    // message 2 with install set, then MIC and ACK together: both tracked only
    pending_items.push_back(key_msg(ap_a, dir_cl[1], 1'b0, msg2_flags() | KF_INSTALL,
                                    next_us()));
    pending_items.push_back(key_msg(ap_a, dir_cl[1], 1'b0, KF_MIC | KF_ACK | KF_PAIRWISE,
                                    next_us()));
    // fill the table, then evict the oldest slot
    for (int k = 2; k < 9; k++)
      pending_items.push_back(key_msg(ap_a, dir_cl[k], 1'($urandom), msg1_flags(), next_us()));
    // cleanup with time before every stamp, then at the latest time
    pending_items.push_back(ctl_item(FUNC_CLEANUP, '0));
    pending_items.push_back(ctl_item(FUNC_CLEANUP, '1));
    // field extremes
    it = key_msg('1, '1, 1'b1, 16'hFFFF, '1);
    it.frame_flags = 8'hFD;
    pending_items.push_back(it);
    it = key_msg('0, '0, 1'b0, msg1_flags(), '0);
    it.frame_flags = DS_FROM;
    pending_items.push_back(it);

    // Random phases, one timeout setting each; pause until idle in between
    tmo_set[0] = '0;
    tmo_set[1] = 32'd1500;
    tmo_set[2] = '1;
    tmo_set[3] = $urandom;
    tmo_set[4] = TIMEOUT_RST;
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      set_timeout(tmo_set[ph]);
      if (ph % 2 == 1)
        cur_us = TIME_W'({$urandom, $urandom});
      repeat (140) pending_items.push_back(random_item());
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && expected_events.size() == 0)
      $display("eapol_handshake_pair_tracker verification clean");
    else
      $display("eapol_handshake_pair_tracker verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("eapol_handshake_pair_tracker verification failed");
    $finish;
  end

endmodule
